// ===== rtl/sc1kbd_pkg.sv =====
// Shared types, constants and lookup functions for the set-1 scan code decoder.
// No dependencies; imported by scancode_set1_keyboard_decoder.
package sc1kbd_pkg;

   localparam int KEY_CODES = 256;
   localparam int MAP_ROWS  = KEY_CODES / 2;   // two key-code bits per memory row
   localparam int ROW_W     = $clog2(MAP_ROWS);

   localparam logic [7:0] CODE_CAPS   = 8'h0B;
   localparam logic [7:0] CODE_LSHIFT = 8'h0E;
   localparam logic [7:0] CODE_RSHIFT = 8'h0F;
   // both shift codes share one row of the key map
   localparam logic [ROW_W-1:0] SHIFT_ROW = CODE_LSHIFT[7:1];

   typedef enum logic [1:0] {
      EV_IGNORED = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   typedef logic [1:0] map_row_type;

   // Scan index to internal key code; zero marks an unused entry.
   function automatic logic [7:0] scan_to_code(input logic [6:0] idx);
      logic [7:0] c;
      case (idx)
         7'h01: c = 8'h1B;  7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;
         7'h05: c = 8'h34;  7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;
         7'h09: c = 8'h38;  7'h0A: c = 8'h39;  7'h0B: c = 8'h30;  7'h0C: c = 8'h2D;
         7'h0D: c = 8'h3D;  7'h0E: c = 8'h08;  7'h0F: c = 8'h09;
         7'h10: c = 8'h71;  7'h11: c = 8'h77;  7'h12: c = 8'h65;  7'h13: c = 8'h72;
         7'h14: c = 8'h74;  7'h15: c = 8'h79;  7'h16: c = 8'h75;  7'h17: c = 8'h69;
         7'h18: c = 8'h6F;  7'h19: c = 8'h70;  7'h1A: c = 8'h5B;  7'h1B: c = 8'h5D;
         7'h1C: c = 8'h0A;  7'h1D: c = 8'h11;  7'h1E: c = 8'h61;  7'h1F: c = 8'h73;
         7'h20: c = 8'h64;  7'h21: c = 8'h66;  7'h22: c = 8'h67;  7'h23: c = 8'h68;
         7'h24: c = 8'h6A;  7'h25: c = 8'h6B;  7'h26: c = 8'h6C;  7'h27: c = 8'h3B;
         7'h28: c = 8'h27;  7'h29: c = 8'h60;  7'h2A: c = 8'h0E;  7'h2B: c = 8'h5C;
         7'h2C: c = 8'h7A;  7'h2D: c = 8'h78;  7'h2E: c = 8'h63;  7'h2F: c = 8'h76;
         7'h30: c = 8'h62;  7'h31: c = 8'h6E;  7'h32: c = 8'h6D;  7'h33: c = 8'h2C;
         7'h34: c = 8'h2E;  7'h35: c = 8'h2F;  7'h36: c = 8'h0F;  7'h37: c = 8'hFA;
         7'h38: c = 8'h12;  7'h39: c = 8'h20;  7'h3A: c = 8'h0B;  7'h3B: c = 8'h80;
         7'h3C: c = 8'h81;  7'h3D: c = 8'h82;  7'h3E: c = 8'h83;  7'h3F: c = 8'h84;
         7'h40: c = 8'h85;  7'h41: c = 8'h86;  7'h42: c = 8'h87;  7'h43: c = 8'h88;
         7'h44: c = 8'h89;  7'h45: c = 8'h0C;  7'h47: c = 8'h93;
         7'h48: c = 8'h94;  7'h49: c = 8'h95;  7'h4A: c = 8'hFC;  7'h4B: c = 8'h90;
         7'h4C: c = 8'h91;  7'h4D: c = 8'h92;  7'h4E: c = 8'hFD;  7'h4F: c = 8'h8D;
         7'h50: c = 8'h8E;  7'h51: c = 8'h8F;  7'h52: c = 8'h8C;  7'h53: c = 8'hFF;
         7'h57: c = 8'h8A;  7'h58: c = 8'h8B;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_printable(input logic [7:0] c);
      return (c >= 8'd32 && c < 8'd128) || c == 8'h0A || c == 8'h0D || c == 8'h09;
   endfunction

   // Other-case form of a character, or the character itself when it has none.
   function automatic logic [6:0] swap_case(input logic [6:0] c);
      logic [6:0] r;
      if (c >= 7'h61 && c <= 7'h7A) begin
         r = c - 7'd32;
      end else begin
         case (c)
            7'h30: r = 7'h29;  7'h31: r = 7'h21;  7'h32: r = 7'h40;  7'h33: r = 7'h23;
            7'h34: r = 7'h24;  7'h35: r = 7'h25;  7'h36: r = 7'h5E;  7'h37: r = 7'h26;
            7'h38: r = 7'h2A;  7'h39: r = 7'h28;
            7'h60: r = 7'h7E;  7'h3D: r = 7'h2B;  7'h5B: r = 7'h7B;  7'h5D: r = 7'h7D;
            7'h3B: r = 7'h3A;  7'h27: r = 7'h22;  7'h2C: r = 7'h3C;  7'h2E: r = 7'h3E;
            7'h2F: r = 7'h3F;
            default: r = c;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== rtl/scancode_set1_keyboard_decoder.sv =====
// Set-1 scan code keyboard decoder: key-down map in a 128x2 synchronous RAM,
// caps flag, case mapping. Depends on sc1kbd_pkg.
// Pipeline: RAM read into stage 1, then modify/write-back into the output register.
// Throughput: one beat per cycle unless the output stalls; the read-modify-write loop
// closes through a one-deep write-to-read forward, so beats to one row run back to back.
// Reset: synchronous; clears control state and caps, then sweeps the key map RAM
// one row a cycle, with req_ready low throughout the sweep.
module scancode_set1_keyboard_decoder
   import sc1kbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_key_code,
   output logic       rsp_char_valid,
   output logic [6:0] rsp_character,
   output logic       rsp_caps_active,
   output logic       rsp_shift_held
);

   // Key-down map: row = code[7:1], bit within the row = code[0].
   map_row_type key_map_mem [MAP_ROWS];

   // Clearing sweep after reset; the top bit set means the sweep is done.
   logic [ROW_W:0] clr_cnt_ff, clr_cnt_in;
   logic           clr_busy;

   // Stage 1: RAM read data plus the beat's decoded fields
   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_code_ff;
   logic             s1_release_ff;
   map_row_type      rd_row_ff;
   logic             fwd_hit_ff;
   map_row_type      fwd_row_ff;

   // Architectural flags outside the RAM
   logic             caps_ff, caps_in;
   map_row_type      shift_row_ff, shift_row_in;   // shadow of the shift row

   // Output register
   logic             out_valid_ff, out_valid_in;
   event_kind_type   out_kind_ff;
   logic [7:0]       out_code_ff;
   logic             out_cvalid_ff;
   logic [6:0]       out_char_ff;
   logic             out_caps_ff;
   logic             out_shift_ff;

   logic             req_fire;
   logic [7:0]       req_code;
   logic [ROW_W-1:0] req_row;

   logic             s1_adv;
   logic             s1_hit;
   logic             s1_wr;
   logic [ROW_W-1:0] s1_row;
   map_row_type      s1_old_row;
   map_row_type      s1_new_row;
   event_kind_type   s1_kind;
   logic             s1_shift;
   logic             s1_cvalid;
   logic [6:0]       s1_char;

   assign clr_busy = ~clr_cnt_ff[ROW_W];
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   // Stage 1 moves on whenever the output register is free or being emptied.
   assign s1_adv    = ~out_valid_ff | rsp_ready;
   assign req_ready = ~clr_busy & (~s1_valid_ff | s1_adv);
   assign req_fire  = req_valid & req_ready;

   // Table lookup ahead of the RAM so the row address is ready at the accept edge
   assign req_code = scan_to_code(req_scan_code[6:0]);
   assign req_row  = req_code[7:1];

   assign s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // Read-modify-write of the key map row
   always_comb begin
      s1_row     = s1_code_ff[7:1];
      s1_hit     = (s1_code_ff != 8'h00);
      s1_old_row = fwd_hit_ff ? fwd_row_ff : rd_row_ff;
      s1_new_row = s1_old_row;
      s1_new_row[s1_code_ff[0]] = ~s1_release_ff;
      s1_wr      = s1_valid_ff & s1_adv & s1_hit;

      if (!s1_hit) begin
         s1_kind = EV_IGNORED;
      end else if (s1_release_ff) begin
         s1_kind = EV_RELEASE;
      end else begin
         s1_kind = EV_PRESS;
      end

      caps_in = caps_ff;
      shift_row_in = shift_row_ff;
      if (s1_valid_ff && s1_adv) begin
         if (s1_kind == EV_PRESS && s1_code_ff == CODE_CAPS) begin
            caps_in = ~caps_ff;
         end
         if (s1_hit && s1_row == SHIFT_ROW) begin
            shift_row_in = s1_new_row;
         end
      end

      // Flags as they stand after this beat
      s1_shift  = (s1_hit && s1_row == SHIFT_ROW) ? |s1_new_row : |shift_row_ff;
      s1_cvalid = (s1_kind == EV_PRESS) && is_printable(s1_code_ff);
      s1_char   = 7'd0;
      if (s1_cvalid) begin
         s1_char = s1_code_ff[6:0];
         if (s1_shift != (caps_ff ^ (s1_code_ff == CODE_CAPS))) begin
            s1_char = swap_case(s1_code_ff[6:0]);
         end
      end
   end

   assign out_valid_in = s1_adv ? s1_valid_ff : out_valid_ff;

   // RAM: one write port (sweep or write-back), one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         key_map_mem[clr_cnt_ff[ROW_W-1:0]] <= '0;
      end else if (s1_wr) begin
         key_map_mem[s1_row] <= s1_new_row;
      end
      if (req_fire) begin
         rd_row_ff <= key_map_mem[req_row];
      end
   end

   // Stage 1 payload; catch a write-back to the row being read at this edge
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_code_ff    <= req_code;
         s1_release_ff <= req_scan_code[7];
         fwd_hit_ff    <= s1_wr && (s1_row == req_row);
         fwd_row_ff    <= s1_new_row;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_adv) begin
         out_kind_ff   <= s1_kind;
         out_code_ff   <= s1_code_ff;
         out_cvalid_ff <= s1_cvalid;
         out_char_ff   <= s1_char;
         out_caps_ff   <= caps_in;
         out_shift_ff  <= s1_shift;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         caps_ff      <= 1'b0;
         shift_row_ff <= '0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         caps_ff      <= caps_in;
         shift_row_ff <= shift_row_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_key_code    = out_code_ff;
   assign rsp_char_valid  = out_cvalid_ff;
   assign rsp_character   = out_char_ff;
   assign rsp_caps_active = out_caps_ff;
   assign rsp_shift_held  = out_shift_ff;

   // Hold off beats until the sweep has cleared the whole map.
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready)
      else $error("beat accepted during key map sweep");

   // The shift shadow tracks its RAM row once the sweep is done.
   a_shadow_matches_ram: assert property (@(posedge clock) disable iff (reset)
      !clr_busy |-> (key_map_mem[SHIFT_ROW] == shift_row_ff))
      else $error("shift shadow differs from key map row");

   // A character only ever comes with a press.
   a_char_on_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_valid) |-> (rsp_event_kind == EV_PRESS))
      else $error("character on a non-press beat");

   // Caps toggles on a caps press as it leaves stage 1.
   a_caps_toggle: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_adv && s1_kind == EV_PRESS && s1_code_ff == CODE_CAPS)
      |=> (caps_ff != $past(caps_ff)))
      else $error("caps flag missed a toggle");

endmodule

// ===== tb/sc1kbd_tb_pkg.sv =====
// Scoreboard for the set-1 scan code decoder bench: scan decoding, held-key and
// caps tracking, and the queue of expected result beats. Depends on sc1kbd_pkg.
`timescale 1ns / 1ps
package sc1kbd_tb_pkg;
   import sc1kbd_pkg::*;

   localparam int TABLE_LAST = 'h58;

   // scan index -> key code, index 0 on the left
   localparam logic [0:88][7:0] SCAN_TABLE = {
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h11, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h0E, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h0F, 8'hFA,
      8'h12, 8'h20, 8'h0B, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
      8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h0C, 8'h00, 8'h93,
      8'h94, 8'h95, 8'hFC, 8'h90, 8'h91, 8'h92, 8'hFD, 8'h8D,
      8'h8E, 8'h8F, 8'h8C, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h8A,
      8'h8B
   };

   // non-letter keys with a shifted form, paired position by position
   localparam logic [0:18][7:0] PLAIN_KEYS   = {"0123456789", 8'h60, "=[];',./"};
   localparam logic [0:18][7:0] SHIFTED_KEYS = {")!@#$%^&*(~+{}:", 8'h22, "<>?"};

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     key_code;
      logic           char_valid;
      logic [6:0]     character;
      logic           caps;
      logic           shift;
   } key_result_type;

   class keystroke_scoreboard;
      bit             key_held [KEY_CODES];
      bit             caps_on;
      key_result_type expected_keys [$];
      int             accepted;
      int             results_seen;
      int             errors;

      task report(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function logic [6:0] other_case(logic [6:0] c);
         int i;
         if (c >= 7'h61 && c <= 7'h7A)
            return c - 7'd32;
         for (i = 0; i < 19; i++)
            if (PLAIN_KEYS[i][6:0] == c)
               return SHIFTED_KEYS[i][6:0];
         return c;
      endfunction

      function key_result_type decode_scan(logic [7:0] scan);
         key_result_type r;
         logic [7:0]     code;
         logic           is_release;
         r          = '0;
         is_release = scan[7];
         code       = (scan[6:0] <= TABLE_LAST) ? SCAN_TABLE[scan[6:0]] : 8'h00;
         r.kind     = EV_IGNORED;
         r.key_code = code;
         if (code != 8'h00) begin
            key_held[code] = !is_release;
            if (is_release) begin
               r.kind = EV_RELEASE;
            end else begin
               r.kind = EV_PRESS;
               if (code == CODE_CAPS)
                  caps_on = !caps_on;
            end
         end
         r.shift = key_held[CODE_LSHIFT] | key_held[CODE_RSHIFT];
         r.caps  = caps_on;
         if (r.kind == EV_PRESS && ((code >= 8'd32 && code < 8'd128) ||
             code == 8'h0A || code == 8'h0D || code == 8'h09)) begin
            r.char_valid = 1'b1;
            r.character  = (r.shift ^ caps_on) ? other_case(code[6:0]) : code[6:0];
         end
         return r;
      endfunction

      function void note_scan(logic [7:0] scan);
         expected_keys.push_back(decode_scan(scan));
         accepted++;
      endfunction

      function string diff_text(string field, int got, int want);
         return $sformatf("result %0d %s: got %0h, want %0h", results_seen, field, got, want);
      endfunction

      task check_result(key_result_type got);
         key_result_type want;
         if (expected_keys.size() == 0) begin
            report($sformatf("result beat with nothing outstanding (kind %0d, code %0h)",
                             got.kind, got.key_code));
            return;
         end
         want = expected_keys.pop_front();
         if (got.kind != want.kind)
            report(diff_text("event_kind", got.kind, want.kind));
         if (got.key_code != want.key_code)
            report(diff_text("key_code", got.key_code, want.key_code));
         if (got.char_valid != want.char_valid)
            report(diff_text("char_valid", got.char_valid, want.char_valid));
         if (got.character != want.character)
            report(diff_text("character", got.character, want.character));
         if (got.caps != want.caps)
            report(diff_text("caps_active", got.caps, want.caps));
         if (got.shift != want.shift)
            report(diff_text("shift_held", got.shift, want.shift));
         results_seen++;
      endtask

      function int pending();
         return expected_keys.size();
      endfunction
   endclass

endpackage

// ===== tb/scancode_set1_keyboard_decoder_tb.sv =====
// Top-level bench for scancode_set1_keyboard_decoder: drives scan bytes, idles
// both channels at random and checks every result beat. Depends on sc1kbd_tb_pkg.
`timescale 1ns / 1ps
module scancode_set1_keyboard_decoder_tb;
   import sc1kbd_pkg::*;
   import sc1kbd_tb_pkg::*;

   localparam int RANDOM_SCANS  = 650;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 120;   // receiver hold-off, long enough to back up the input
   localparam int HOLD_AFTER    = 200;   // input beats accepted before that hold-off
   localparam int DRAIN_AT      = 400;   // scans sent before the sender waits for a drain
   localparam int SETTLE_CYCLES = 8;

   // Opening sequence: empty entries, out-of-range indexes, a release of an
   // empty entry, caps on and off and each shift held once, the keys without a
   // shifted form, tab/newline/space, the top table code and the last index.
   localparam logic [0:24][7:0] OPENING_SCANS = {
      8'h00, 8'h80, 8'h46, 8'h59, 8'h7F, 8'hFF,    // ignored beats
      8'h1E, 8'h3A, 8'h1E,                         // 'a', caps on, 'A'
      8'h2A, 8'h1E, 8'h02, 8'hAA,                  // left shift with caps: 'a', '1'
      8'h3A, 8'h36, 8'h29, 8'h02, 8'h2B, 8'hB6,    // caps off, right shift: '~', '!', '\'
      8'h1C, 8'h0F, 8'h39,                         // newline, tab, space
      8'h53, 8'hD3, 8'h58                          // code FF press/release, last index
   };

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_scan_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [7:0] rsp_key_code;
   logic       rsp_char_valid;
   logic [6:0] rsp_character;
   logic       rsp_caps_active;
   logic       rsp_shift_held;

   keystroke_scoreboard sb = new();
   key_result_type      seen;
   bit                  steady;          // no random gaps on either side while set
   bit                  long_hold_done;
   int                  scans_sent;
   int                  cycle_count;

   always #5 clock = ~clock;

   scancode_set1_keyboard_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_scan_code   (req_scan_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_key_code    (rsp_key_code),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_character   (rsp_character),
      .rsp_caps_active (rsp_caps_active),
      .rsp_shift_held  (rsp_shift_held)
   );

   // Gap length in cycles: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one scan byte and hold it until the beat is taken. With no gap,
   // valid stays high so the next call can present its byte at the same edge.
   task automatic send_scan(input logic [7:0] scan);
      int gap;
      req_valid     <= 1'b1;
      req_scan_code <= scan;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      scans_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every outstanding result beat has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // A burst of typing: optionally hold a shift, press keys with random
   // content, release most of them, then let go of the shift.
   task automatic type_phrase();
      logic [7:0] shift_scan;
      logic [6:0] key;
      bit         with_shift;
      int         keys;
      shift_scan = $urandom_range(0, 1) ? 8'h2A : 8'h36;
      with_shift = ($urandom_range(0, 2) == 0);
      keys       = $urandom_range(1, 6);
      if (with_shift)
         send_scan(shift_scan);
      repeat (keys) begin
         key = 7'($urandom_range(1, TABLE_LAST));
         send_scan({1'b0, key});
         if ($urandom_range(0, 3) != 0)
            send_scan({1'b1, key});
      end
      if (with_shift)
         send_scan(shift_scan | 8'h80);
   endtask

   // Note accepted scan beats and check result beats; both use the values
   // from just before the edge, so the order of processes does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_scan(req_scan_code);
         if (rsp_valid && rsp_ready) begin
            seen.kind       = event_kind_type'(rsp_event_kind);
            seen.key_code   = rsp_key_code;
            seen.char_valid = rsp_char_valid;
            seen.character  = rsp_character;
            seen.caps       = rsp_caps_active;
            seen.shift      = rsp_shift_held;
            sb.check_result(seen);
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off once enough beats have
   // gone in, so the block fills up and has to push back on its input.
   initial begin : result_sink
      int stall;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!long_hold_done && sb.accepted >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Watchdog: covers the key map sweep after reset with plenty to spare.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, sb.pending());
         $display("status: fail");
         $finish;
      end
   end

   initial begin : scan_source
      int  next_phase;
      int  roll;
      bit  drained_once;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening; the block's ready stays low through its map sweep.
      for (int i = 0; i < 25; i++)
         send_scan(OPENING_SCANS[i]);
      pause_until_drained();

      // Random part: phases of about sixty scans, some of them with no idling.
      next_phase = scans_sent;
      while (scans_sent < 25 + RANDOM_SCANS) begin
         if (scans_sent >= next_phase) begin
            steady     = ($urandom_range(0, 3) == 0);
            next_phase = scans_sent + 60;
            if (!drained_once && scans_sent >= DRAIN_AT) begin
               pause_until_drained();
               drained_once = 1'b1;
            end
         end
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            type_phrase();
         end else if (roll < 85) begin
            // toggle caps; release it only some of the time
            send_scan(8'h3A);
            if ($urandom_range(0, 1))
               send_scan(8'hBA);
         end else begin
            // noise: any byte, including out-of-range and empty entries
            send_scan(8'($urandom_range(0, 255)));
         end
      end

      // Drain, then give stray beats a chance to show up.
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d result beats never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
